FILE: design/ihl_pkg.sv
// Shared types, codes and field widths for the indexed handle list table.
package ihl_pkg;

  localparam int unsigned CapacityDef   = 64;
  localparam int unsigned HandleBitsDef = 32;

  localparam int unsigned ReqW       = 3;
  localparam int unsigned PosW       = 6;
  localparam int unsigned HandleW    = 32;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned CountOutW  = 7;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 48;

  typedef enum logic [ReqW-1:0] {
    ReqAppend = 3'd0,
    ReqInsert = 3'd1,
    ReqDelete = 3'd2,
    ReqRemove = 3'd3,
    ReqSwap   = 3'd4,
    ReqFind   = 3'd5,
    ReqClear  = 3'd6,
    ReqPack   = 3'd7
  } req_e;

  localparam logic [StatusW-1:0] StatOk   = 2'd0;
  localparam logic [StatusW-1:0] StatMiss = 2'd1;
  localparam logic [StatusW-1:0] StatFull = 2'd2;

  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [PosW-1:0]      position;
    logic [HandleW-1:0]   handle;
    logic [CountOutW-1:0] count;
  } res_t;

endpackage

FILE: design/ihl_mem.sv
// Slot memory: one write port and one read port with registered read data.
module ihl_mem #(
  parameter int unsigned Depth = ihl_pkg::CapacityDef,
  parameter int unsigned Width = ihl_pkg::HandleBitsDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ihl_seq.sv
// Request sequencer: decodes a request and walks the slot memory to serve it.
module ihl_seq #(
  parameter int unsigned Capacity   = ihl_pkg::CapacityDef,
  parameter int unsigned HandleBits = ihl_pkg::HandleBitsDef,
  parameter int unsigned AddrW      = $clog2(Capacity),
  parameter int unsigned CountW     = $clog2(Capacity + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ihl_pkg::req_e              req_i,
  input  logic [ihl_pkg::PosW-1:0]   pos_i,
  input  logic [ihl_pkg::PosW-1:0]   pos2_i,
  input  logic [HandleBits-1:0]      handle_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output ihl_pkg::res_t              res_o,
  output logic                       mem_we_o,
  output logic [AddrW-1:0]           mem_waddr_o,
  output logic [HandleBits-1:0]      mem_wdata_o,
  output logic [AddrW-1:0]           mem_raddr_o,
  input  logic [HandleBits-1:0]      mem_rdata_i
);

  localparam int unsigned CmpW = (CountW > ihl_pkg::PosW) ? CountW : ihl_pkg::PosW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDec  = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StShUp = 3'd3;
  localparam logic [2:0] StSw2  = 3'd4;
  localparam logic [2:0] StSw3  = 3'd5;
  localparam logic [2:0] StSw4  = 3'd6;
  localparam logic [2:0] StDone = 3'd7;

  logic [2:0]                   state_q, state_d;
  ihl_pkg::req_e                req_q, req_d;
  logic [ihl_pkg::PosW-1:0]     p_q, p_d, p2_q, p2_d;
  logic [HandleBits-1:0]        h_q, h_d;
  logic [CountW-1:0]            count_q, count_d;
  logic [CountW-1:0]            rd_idx_q, rd_idx_d;
  logic [CountW-1:0]            wr_q, wr_d;
  logic                         more_q, more_d;
  logic                         vld_q, vld_d;
  logic [AddrW-1:0]             didx_q, didx_d;
  logic                         found_q, found_d;
  logic [AddrW-1:0]             at_q, at_d;
  logic [HandleBits-1:0]        tmp_q, tmp_d;
  logic [ihl_pkg::StatusW-1:0]  rstat_q, rstat_d;
  logic [ihl_pkg::PosW-1:0]     rpos_q, rpos_d;
  logic [ihl_pkg::HandleW-1:0]  rhdl_q, rhdl_d;

  logic [CmpW-1:0] p_ext, p2_ext, cnt_ext;
  logic            match, drop;

  assign p_ext   = CmpW'(p_q);
  assign p2_ext  = CmpW'(p2_q);
  assign cnt_ext = CmpW'(count_q);
  assign match   = (mem_rdata_i == h_q);

  always_comb begin
    drop = 1'b0;
    case (req_q)
      ihl_pkg::ReqDelete: drop = (didx_q == AddrW'(p_q));
      ihl_pkg::ReqRemove: drop = match && !found_q;
      ihl_pkg::ReqPack:   drop = (mem_rdata_i == '0);
      default:            drop = 1'b0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    p_d      = p_q;
    p2_d     = p2_q;
    h_d      = h_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    wr_d     = wr_q;
    more_d   = more_q;
    vld_d    = vld_q;
    didx_d   = didx_q;
    found_d  = found_q;
    at_d     = at_q;
    tmp_d    = tmp_q;
    rstat_d  = rstat_q;
    rpos_d   = rpos_q;
    rhdl_d   = rhdl_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_raddr_o = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          req_d   = req_i;
          p_d     = pos_i;
          p2_d    = pos2_i;
          h_d     = handle_i;
          state_d = StDec;
        end
      end
      StDec: begin
        rstat_d  = ihl_pkg::StatOk;
        rpos_d   = '0;
        rhdl_d   = '0;
        rd_idx_d = '0;
        wr_d     = '0;
        vld_d    = 1'b0;
        found_d  = 1'b0;
        state_d  = StDone;
        unique case (req_q) inside
          ihl_pkg::ReqAppend, ihl_pkg::ReqInsert: begin
            if (count_q == CountW'(Capacity)) begin
              rstat_d = ihl_pkg::StatFull;
            end else if (req_q == ihl_pkg::ReqAppend || p_ext >= cnt_ext) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = AddrW'(count_q);
              mem_wdata_o = h_q;
              count_d     = count_q + CountW'(1);
              rpos_d      = ihl_pkg::PosW'(count_q);
            end else begin
              rd_idx_d = count_q - CountW'(1);
              more_d   = 1'b1;
              state_d  = StShUp;
            end
          end
          ihl_pkg::ReqDelete: begin
            if (p_ext >= cnt_ext) begin
              rstat_d = ihl_pkg::StatMiss;
            end else begin
              rd_idx_d = CountW'(p_q);
              wr_d     = CountW'(p_q);
              state_d  = StScan;
            end
          end
          ihl_pkg::ReqRemove, ihl_pkg::ReqFind, ihl_pkg::ReqPack: begin
            state_d = StScan;
          end
          ihl_pkg::ReqSwap: begin
            if (p_ext >= cnt_ext || p2_ext >= cnt_ext) begin
              rstat_d = ihl_pkg::StatMiss;
            end else begin
              mem_raddr_o = AddrW'(p_q);
              state_d     = StSw2;
            end
          end
          ihl_pkg::ReqClear: begin
            count_d = '0;
          end
        endcase
      end
      StScan: begin
        if (rd_idx_q < count_q) begin
          mem_raddr_o = AddrW'(rd_idx_q);
          rd_idx_d    = rd_idx_q + CountW'(1);
          vld_d       = 1'b1;
          didx_d      = AddrW'(rd_idx_q);
        end else begin
          vld_d = 1'b0;
        end
        if (vld_q) begin
          if (req_q == ihl_pkg::ReqDelete && didx_q == AddrW'(p_q)) begin
            tmp_d = mem_rdata_i;
          end
          if (match && !found_q) begin
            found_d = 1'b1;
            at_d    = didx_q;
          end
          if (!drop && req_q != ihl_pkg::ReqFind) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = AddrW'(wr_q);
            mem_wdata_o = mem_rdata_i;
            wr_d        = wr_q + CountW'(1);
          end
        end
        if (rd_idx_q >= count_q && !vld_q) begin
          state_d = StDone;
          case (req_q) inside
            ihl_pkg::ReqDelete: begin
              rpos_d  = p_q;
              rhdl_d  = ihl_pkg::HandleW'(tmp_q);
              count_d = wr_q;
            end
            ihl_pkg::ReqRemove, ihl_pkg::ReqFind: begin
              if (found_q) begin
                rpos_d = ihl_pkg::PosW'(at_q);
              end else begin
                rstat_d = ihl_pkg::StatMiss;
              end
              if (req_q == ihl_pkg::ReqRemove) begin
                count_d = wr_q;
              end
            end
            default: begin
              count_d = wr_q;
            end
          endcase
        end
      end
      StShUp: begin
        if (more_q) begin
          mem_raddr_o = AddrW'(rd_idx_q);
          vld_d       = 1'b1;
          didx_d      = AddrW'(rd_idx_q);
          if (CmpW'(rd_idx_q) == p_ext) begin
            more_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q - CountW'(1);
          end
        end else begin
          vld_d = 1'b0;
        end
        if (vld_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = didx_q + AddrW'(1);
          mem_wdata_o = mem_rdata_i;
        end else if (!more_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = AddrW'(p_q);
          mem_wdata_o = h_q;
          count_d     = count_q + CountW'(1);
          rpos_d      = p_q;
          state_d     = StDone;
        end
      end
      StSw2: begin
        tmp_d       = mem_rdata_i;
        mem_raddr_o = AddrW'(p2_q);
        state_d     = StSw3;
      end
      StSw3: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(p_q);
        mem_wdata_o = mem_rdata_i;
        state_d     = StSw4;
      end
      StSw4: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = AddrW'(p2_q);
        mem_wdata_o = tmp_q;
        rpos_d      = p_q;
        state_d     = StDone;
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      more_q  <= 1'b0;
      vld_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      more_q  <= more_d;
      vld_q   <= vld_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    p_q      <= p_d;
    p2_q     <= p2_d;
    h_q      <= h_d;
    rd_idx_q <= rd_idx_d;
    wr_q     <= wr_d;
    didx_q   <= didx_d;
    at_q     <= at_d;
    tmp_q    <= tmp_d;
    rstat_q  <= rstat_d;
    rpos_q   <= rpos_d;
    rhdl_q   <= rhdl_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);

  always_comb begin
    res_o.status   = rstat_q;
    res_o.position = rpos_q;
    res_o.handle   = rhdl_q;
    res_o.count    = ihl_pkg::CountOutW'(count_q);
  end

endmodule

FILE: design/indexed_handle_list_table_unit.sv
// Append, clear and full or out-of-range rejects finish in the decode state; insert and delete
// walk the slots from the end or from the position, remove, find and pack scan the whole list,
// one slot memory read per cycle, and swap reads both slots and writes them back in turn.
// One request is served at a time: the next can be accepted in the cycle after a result
// is handed to the output register.
// Reset empties the list at once; slot contents stay undefined until written.
module indexed_handle_list_table_unit #(
  parameter int unsigned CAPACITY    = ihl_pkg::CapacityDef,
  parameter int unsigned HANDLE_BITS = ihl_pkg::HandleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // position [5:0], second_position [11:6], item_handle [43:12], zero fill [47:44]
  input  logic [ihl_pkg::InDataW-1:0]   s_axis_tdata_i,
  // req_type [2:0]
  input  logic [ihl_pkg::ReqW-1:0]      s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status [1:0], result_position [7:2], result_handle [39:8], entry_count [46:40],
  // zero fill [47]
  output logic [ihl_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned AddrW  = $clog2(CAPACITY);
  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  logic                     res_valid, res_ready;
  ihl_pkg::res_t            res;
  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr, mem_raddr;
  logic [HANDLE_BITS-1:0]   mem_wdata, mem_rdata;
  logic [HANDLE_BITS-1:0]   in_handle;

  logic                     out_valid_q, out_valid_d;
  ihl_pkg::res_t            out_q, out_d;

  assign in_handle = HANDLE_BITS'(s_axis_tdata_i[43:12]);

  ihl_seq #(
    .Capacity  (CAPACITY),
    .HandleBits(HANDLE_BITS),
    .AddrW     (AddrW),
    .CountW    (CountW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .req_i      (ihl_pkg::req_e'(s_axis_tuser_i)),
    .pos_i      (s_axis_tdata_i[5:0]),
    .pos2_i     (s_axis_tdata_i[11:6]),
    .handle_i   (in_handle),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  ihl_mem #(
    .Depth(CAPACITY),
    .Width(HANDLE_BITS),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.count, out_q.handle, out_q.position, out_q.status};

endmodule
